// ===== hdl/rwl_pkg.sv =====
package rwl_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS = 8;
	localparam int WHO_W = 8;
	localparam int RC_W = 9;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [WHO_W-1:0] who_t;
	typedef logic [RC_W-1:0] rc_t;
	typedef logic [QPTR_W-1:0] qptr_t;
	typedef logic [QCNT_W-1:0] qcnt_t;

	localparam rc_t RC_MAX = {RC_W{1'b1}};

	typedef enum logic [1:0] {
		CMD_ACQ_RD = 2'd0,
		CMD_ACQ_WR = 2'd1,
		CMD_REL_RD = 2'd2,
		CMD_REL_WR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_GRANT     = 3'd0,
		EV_QUEUED    = 3'd1,
		EV_WAITER    = 3'd2,
		EV_RELEASED  = 3'd3,
		EV_FULL      = 3'd4,
		EV_UNDERFLOW = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WAKE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic exec;
		logic wake_pop;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic wake;
		logic rq_last;
	} dp_status_t;

	function automatic qptr_t next_ptr(qptr_t p);
		next_ptr = (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ===== hdl/reader_writer_lock_arbiter_core.sv =====
// Channel   Direction  Handshake            Beat payload
// input     in         in_valid / in_stall   cmd, requester
// result    out        out_valid / out_stall event_res, who, for_write, readers_now, last
//
// Each request has two steps: one to capture the beat, one to decide and
// load the result register. A write release that wakes readers makes no result
// beat at its decision step; the wake sweep then gives each woken reader its own
// result beat.
// Reset (arst_n low) clears the lock, reader count and queue pointers.
// A stalled result holds the decision step; a new request is taken while the
// previous result still waits downstream.
module reader_writer_lock_arbiter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] requester,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [7:0] who,
	output logic       for_write,
	output logic [8:0] readers_now,
	output logic       last
);

	// control and status between the state machine and the datapath
	rwl_pkg::ctrl_cmd_t  ctl;
	rwl_pkg::dp_status_t sts;

	// Sequence requests: capture, decide, then sweep waiting readers on a wake.
	rwl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (ctl)
	);

	// Hold lock state, both wait queues and the result register.
	rwl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (ctl),
		.sts         (sts),
		.cmd_in      (cmd),
		.requester   (requester),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.who         (who),
		.for_write   (for_write),
		.readers_now (readers_now),
		.last        (last)
	);

endmodule

// ===== hdl/rwl_ctrl.sv =====
module rwl_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  rwl_pkg::dp_status_t    sts,
	output rwl_pkg::ctrl_cmd_t     cmd
);

	rwl_pkg::state_t state_q;
	rwl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwl_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		in_stall     = (state_q != rwl_pkg::ST_IDLE);
		case (state_q)
			rwl_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = rwl_pkg::ST_EXEC;
				end
			end
			rwl_pkg::ST_EXEC: begin
				// wait for room in the output register
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = sts.wake ? rwl_pkg::ST_WAKE : rwl_pkg::ST_IDLE;
				end
			end
			rwl_pkg::ST_WAKE: begin
				// drain waiting readers one beat at a time
				if (sts.out_free) begin
					cmd.wake_pop = 1'b1;
					if (sts.rq_last) begin
						state_d = rwl_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = rwl_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/rwl_dp.sv =====
module rwl_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rwl_pkg::ctrl_cmd_t     cmd,
	output rwl_pkg::dp_status_t    sts,
	input  logic [1:0]             cmd_in,
	input  logic [7:0]             requester,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [2:0]             event_res,
	output logic [7:0]             who,
	output logic                   for_write,
	output logic [8:0]             readers_now,
	output logic                   last
);

	// latched request
	rwl_pkg::cmd_t   op_q;
	rwl_pkg::id_t    req_q;

	// lock state
	logic            wa_q;
	rwl_pkg::rc_t    rc_q;

	// wait queues
	rwl_pkg::id_t    rq_mem [rwl_pkg::QUEUE_DEPTH];
	rwl_pkg::id_t    wq_mem [rwl_pkg::QUEUE_DEPTH];
	rwl_pkg::qptr_t  rq_head_q, rq_tail_q, wq_head_q, wq_tail_q;
	rwl_pkg::qcnt_t  rq_cnt_q, wq_cnt_q;

	// output register
	logic            out_valid_q;
	rwl_pkg::event_t ev_q;
	rwl_pkg::who_t   who_q;
	logic            fw_q;
	rwl_pkg::rc_t    rn_q;
	logic            last_q;

	// step decode
	rwl_pkg::event_t ev_c;
	rwl_pkg::id_t    who_c;
	logic            fw_c;
	rwl_pkg::rc_t    rc_c;
	logic            wa_c;
	logic            push_r, push_w, pop_w, wake_c;
	logic            rq_full, wq_full;
	rwl_pkg::id_t    rq_head_id, wq_head_id;
	rwl_pkg::rc_t    rc_wake;
	logic            emit_exec;

	assign rq_full    = (rq_cnt_q == rwl_pkg::qcnt_t'(rwl_pkg::QUEUE_DEPTH));
	assign wq_full    = (wq_cnt_q == rwl_pkg::qcnt_t'(rwl_pkg::QUEUE_DEPTH));
	assign rq_head_id = rq_mem[rq_head_q];
	assign wq_head_id = wq_mem[wq_head_q];
	assign rc_wake    = (rc_q == rwl_pkg::RC_MAX) ? rc_q : rc_q + 1'b1;

	always_comb begin
		ev_c   = rwl_pkg::EV_GRANT;
		who_c  = req_q;
		fw_c   = 1'b0;
		rc_c   = rc_q;
		wa_c   = wa_q;
		push_r = 1'b0;
		push_w = 1'b0;
		pop_w  = 1'b0;
		wake_c = 1'b0;
		case (op_q)
			rwl_pkg::CMD_ACQ_RD: begin
				if (wa_q) begin
					if (rq_full) begin
						ev_c = rwl_pkg::EV_FULL;
					end else begin
						push_r = 1'b1;
						ev_c   = rwl_pkg::EV_QUEUED;
					end
				end else if (rc_q == rwl_pkg::RC_MAX) begin
					ev_c = rwl_pkg::EV_FULL;
				end else begin
					rc_c = rc_q + 1'b1;
				end
			end
			rwl_pkg::CMD_ACQ_WR: begin
				fw_c = 1'b1;
				if (!wa_q && rc_q == '0) begin
					wa_c = 1'b1;
				end else if (wq_full) begin
					ev_c = rwl_pkg::EV_FULL;
				end else begin
					push_w = 1'b1;
					ev_c   = rwl_pkg::EV_QUEUED;
				end
			end
			rwl_pkg::CMD_REL_RD: begin
				if (rc_q == '0) begin
					ev_c = rwl_pkg::EV_UNDERFLOW;
				end else begin
					rc_c = rc_q - 1'b1;
					// last reader out hands over to the oldest writer
					if (rc_q == rwl_pkg::rc_t'(1) && wq_cnt_q != '0) begin
						pop_w = 1'b1;
						wa_c  = 1'b1;
						ev_c  = rwl_pkg::EV_WAITER;
						who_c = wq_head_id;
						fw_c  = 1'b1;
					end else begin
						ev_c = rwl_pkg::EV_RELEASED;
					end
				end
			end
			rwl_pkg::CMD_REL_WR: begin
				fw_c = 1'b1;
				if (!wa_q) begin
					ev_c = rwl_pkg::EV_UNDERFLOW;
				end else if (wq_cnt_q != '0) begin
					pop_w = 1'b1;
					ev_c  = rwl_pkg::EV_WAITER;
					who_c = wq_head_id;
				end else begin
					wa_c = 1'b0;
					ev_c = rwl_pkg::EV_RELEASED;
					// readers waiting: no beat now, the wake sweep emits them
					wake_c = (rq_cnt_q != '0);
				end
			end
			default: begin
				ev_c = rwl_pkg::EV_UNDERFLOW;
			end
		endcase
	end

	assign emit_exec = cmd.exec && !wake_c;

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.wake     = wake_c;
	assign sts.rq_last  = (rq_cnt_q == rwl_pkg::qcnt_t'(1));

	// request latch, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= rwl_pkg::cmd_t'(cmd_in);
			req_q <= rwl_pkg::id_t'(requester);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wa_q <= 1'b0;
			rc_q <= '0;
		end else if (cmd.exec) begin
			wa_q <= wa_c;
			rc_q <= rc_c;
		end else if (cmd.wake_pop) begin
			rc_q <= rc_wake;
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (cmd.exec && push_r) begin
			rq_mem[rq_tail_q] <= req_q;
		end
		if (cmd.exec && push_w) begin
			wq_mem[wq_tail_q] <= req_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_head_q <= '0;
			rq_tail_q <= '0;
			rq_cnt_q  <= '0;
		end else if (cmd.exec && push_r) begin
			rq_tail_q <= rwl_pkg::next_ptr(rq_tail_q);
			rq_cnt_q  <= rq_cnt_q + 1'b1;
		end else if (cmd.wake_pop) begin
			rq_head_q <= rwl_pkg::next_ptr(rq_head_q);
			rq_cnt_q  <= rq_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wq_head_q <= '0;
			wq_tail_q <= '0;
			wq_cnt_q  <= '0;
		end else if (cmd.exec && push_w) begin
			wq_tail_q <= rwl_pkg::next_ptr(wq_tail_q);
			wq_cnt_q  <= wq_cnt_q + 1'b1;
		end else if (cmd.exec && pop_w) begin
			wq_head_q <= rwl_pkg::next_ptr(wq_head_q);
			wq_cnt_q  <= wq_cnt_q - 1'b1;
		end
	end

	// output register: load a beat, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_exec || cmd.wake_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_exec) begin
			ev_q   <= ev_c;
			who_q  <= rwl_pkg::who_t'(who_c);
			fw_q   <= fw_c;
			rn_q   <= rc_c;
			last_q <= 1'b1;
		end else if (cmd.wake_pop) begin
			ev_q   <= rwl_pkg::EV_WAITER;
			who_q  <= rwl_pkg::who_t'(rq_head_id);
			fw_q   <= 1'b0;
			rn_q   <= rc_wake;
			last_q <= (rq_cnt_q == rwl_pkg::qcnt_t'(1));
		end
	end

	assign out_valid   = out_valid_q;
	assign event_res   = ev_q;
	assign who         = who_q;
	assign for_write   = fw_q;
	assign readers_now = rn_q;
	assign last        = last_q;

`ifndef SYNTHESIS
	a_wake_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wake_pop |-> rq_cnt_q != '0)
		else $error("reader wake from an empty queue");

	a_writer_excl: assert property (@(posedge clk) disable iff (!arst_n)
		wa_q |-> rc_q == '0)
		else $error("writer holds the lock while readers are counted");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_exec || cmd.wake_pop) |-> !(out_valid_q && out_stall))
		else $error("result overwritten while held");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= rwl_pkg::qcnt_t'(rwl_pkg::QUEUE_DEPTH)
		&& wq_cnt_q <= rwl_pkg::qcnt_t'(rwl_pkg::QUEUE_DEPTH))
		else $error("wait queue count beyond depth");
`endif

endmodule

// ===== verif/rwl_event_checker.sv =====
module rwl_event_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] requester,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [2:0] event_res,
	input  logic [7:0] who,
	input  logic       for_write,
	input  logic [8:0] readers_now,
	input  logic       last,
	output int         mismatch_count,
	output int         beats_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rwl_pkg::event_t code;
		rwl_pkg::who_t   who;
		logic            for_write;
		rwl_pkg::rc_t    readers;
		logic            last;
	} lock_event_t;

	// shadow of the lock
	logic          writer_held;
	rwl_pkg::rc_t  reader_total;
	rwl_pkg::id_t  rd_waiters[$];
	rwl_pkg::id_t  wr_waiters[$];
	lock_event_t   pending_events[$];
	int            errors = 0;

	function automatic void post_event(rwl_pkg::event_t code, rwl_pkg::id_t id, logic wr);
		pending_events.push_back('{code, rwl_pkg::who_t'(id), wr, reader_total, 1'b0});
	endfunction

	task automatic predict_lock_events(input rwl_pkg::cmd_t op, input rwl_pkg::id_t req);
		rwl_pkg::id_t woken_id;
		int           woken;
		woken = 0;
		case (op)
		rwl_pkg::CMD_ACQ_RD: begin
			if (writer_held) begin
				if (rd_waiters.size() >= rwl_pkg::QUEUE_DEPTH) begin
					post_event(rwl_pkg::EV_FULL, req, 1'b0);
				end else begin
					rd_waiters.push_back(req);
					post_event(rwl_pkg::EV_QUEUED, req, 1'b0);
				end
			end else if (reader_total == rwl_pkg::RC_MAX) begin
				post_event(rwl_pkg::EV_FULL, req, 1'b0);
			end else begin
				reader_total++;
				post_event(rwl_pkg::EV_GRANT, req, 1'b0);
			end
		end
		rwl_pkg::CMD_ACQ_WR: begin
			if (!writer_held && reader_total == '0) begin
				writer_held = 1'b1;
				post_event(rwl_pkg::EV_GRANT, req, 1'b1);
			end else if (wr_waiters.size() >= rwl_pkg::QUEUE_DEPTH) begin
				post_event(rwl_pkg::EV_FULL, req, 1'b1);
			end else begin
				wr_waiters.push_back(req);
				post_event(rwl_pkg::EV_QUEUED, req, 1'b1);
			end
		end
		rwl_pkg::CMD_REL_RD: begin
			if (reader_total == '0) begin
				post_event(rwl_pkg::EV_UNDERFLOW, req, 1'b0);
			end else begin
				reader_total--;
				// last reader out hands the lock to the oldest writer
				if (reader_total == '0 && wr_waiters.size() != 0) begin
					writer_held = 1'b1;
					woken_id = wr_waiters.pop_front();
					post_event(rwl_pkg::EV_WAITER, woken_id, 1'b1);
				end else begin
					post_event(rwl_pkg::EV_RELEASED, req, 1'b0);
				end
			end
		end
		default: begin
			if (!writer_held) begin
				post_event(rwl_pkg::EV_UNDERFLOW, req, 1'b1);
			end else if (wr_waiters.size() != 0) begin
				woken_id = wr_waiters.pop_front();
				post_event(rwl_pkg::EV_WAITER, woken_id, 1'b1);
			end else begin
				writer_held = 1'b0;
				if (rd_waiters.size() == 0) begin
					post_event(rwl_pkg::EV_RELEASED, req, 1'b1);
				end else begin
					// wake every waiting reader, oldest first, one beat each
					while (rd_waiters.size() != 0 && woken < rwl_pkg::QUEUE_DEPTH) begin
						woken_id = rd_waiters.pop_front();
						if (reader_total != rwl_pkg::RC_MAX)
							reader_total++;
						post_event(rwl_pkg::EV_WAITER, woken_id, 1'b0);
						woken++;
					end
				end
			end
		end
		endcase
		pending_events[pending_events.size() - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lock_event_t oldest;
		if (!arst_n) begin
			writer_held = 1'b0;
			reader_total = '0;
			rd_waiters.delete();
			wr_waiters.delete();
			pending_events.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_events.size() == 0) begin
					$error("result beat with nothing expected: event_res %0d who %0d",
						event_res, who);
					errors++;
				end else begin
					oldest = pending_events.pop_front();
					if (event_res !== oldest.code) begin
						$error("event_res: expected %0d, got %0d", oldest.code, event_res);
						errors++;
					end
					if (who !== oldest.who) begin
						$error("who: expected %0d, got %0d", oldest.who, who);
						errors++;
					end
					if (for_write !== oldest.for_write) begin
						$error("for_write: expected %0d, got %0d", oldest.for_write, for_write);
						errors++;
					end
					if (readers_now !== oldest.readers) begin
						$error("readers_now: expected %0d, got %0d", oldest.readers,
							readers_now);
						errors++;
					end
					if (last !== oldest.last) begin
						$error("last: expected %0d, got %0d", oldest.last, last);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_lock_events(rwl_pkg::cmd_t'(cmd), rwl_pkg::id_t'(requester));
		end
		mismatch_count <= errors;
		beats_outstanding <= pending_events.size();
	end

endmodule

// ===== verif/tb_reader_writer_lock_arbiter_core.sv =====
module tb_reader_writer_lock_arbiter_core;

	timeunit 1ns;
	timeprecision 1ps;

	// a wake of all readers is the slowest thing the block does; allow well past it
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_REQUESTS = 215;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] cmd = '0;
	logic [7:0] requester = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] event_res;
	logic [7:0] who;
	logic       for_write;
	logic [8:0] readers_now;
	logic       last;

	int mismatch_count;
	int beats_outstanding;
	int cycle_count = 0;
	int requests_sent = 0;
	int burst_left = 0;

	always #5 clk = ~clk;

	reader_writer_lock_arbiter_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.requester  (requester),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.who        (who),
		.for_write  (for_write),
		.readers_now(readers_now),
		.last       (last)
	);

	rwl_event_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.requester        (requester),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_res        (event_res),
		.who              (who),
		.for_write        (for_write),
		.readers_now      (readers_now),
		.last             (last),
		.mismatch_count   (mismatch_count),
		.beats_outstanding(beats_outstanding)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_reader_writer_lock_arbiter_core NOT OK");
			$finish;
		end
	end

	// Result side: switch between stretches of no stall, light and heavy random
	// stall, and long regular stalls, so that stalls land on every wake step.
	initial begin
		int mode;
		int span;
		int tick;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(8, 64);
			for (tick = 0; tick < span; tick++) begin
				@(posedge clk);
				case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 1) == 1);
				2: out_stall <= ($urandom_range(0, 4) == 0);
				default: out_stall <= ((tick % 10) < 7);
				endcase
			end
		end
	end

	function automatic logic [7:0] random_id();
		return 8'($urandom_range(0, 255));
	endfunction

	// Offer one request beat and hold it until taken. Bursts of random length
	// are separated by random gaps; a zero gap keeps valid high across bursts.
	task automatic send_request(input rwl_pkg::cmd_t op, input logic [7:0] id);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		cmd <= op;
		requester <= id;
		do @(posedge clk); while (in_stall);
		requests_sent++;
	endtask

	// Drop valid and hold off until every predicted result beat has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (beats_outstanding != 0);
	endtask

	initial begin
		int  n_rd;
		int  n_wr;
		int  pick;
		int  random_start;
		bit  paused;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: grant, queueing, hand-over to a writer, wake of readers,
		// last reader handing to a writer, plain releases and both underflows.
		send_request(rwl_pkg::CMD_ACQ_WR, 8'hFF);
		send_request(rwl_pkg::CMD_ACQ_WR, 8'h00);
		send_request(rwl_pkg::CMD_ACQ_RD, 8'hAA);
		send_request(rwl_pkg::CMD_ACQ_RD, 8'h55);
		send_request(rwl_pkg::CMD_REL_WR, 8'h01);
		send_request(rwl_pkg::CMD_REL_WR, 8'h02);
		send_request(rwl_pkg::CMD_ACQ_WR, 8'h11);
		send_request(rwl_pkg::CMD_REL_RD, 8'h80);
		send_request(rwl_pkg::CMD_REL_RD, 8'h7F);
		send_request(rwl_pkg::CMD_REL_WR, 8'h11);
		send_request(rwl_pkg::CMD_REL_RD, 8'h33);
		send_request(rwl_pkg::CMD_REL_WR, 8'h44);
		send_request(rwl_pkg::CMD_ACQ_RD, 8'hFE);
		send_request(rwl_pkg::CMD_REL_RD, 8'hFE);
		drain_results();

		// Fill both wait queues past their depth behind a writer, hand the
		// lock down the writer queue, then wake a full queue of readers at once.
		send_request(rwl_pkg::CMD_ACQ_WR, 8'h01);
		repeat (rwl_pkg::QUEUE_DEPTH + 1) send_request(rwl_pkg::CMD_ACQ_RD, random_id());
		repeat (rwl_pkg::QUEUE_DEPTH + 1) send_request(rwl_pkg::CMD_ACQ_WR, random_id());
		repeat (rwl_pkg::QUEUE_DEPTH + 1) send_request(rwl_pkg::CMD_REL_WR, random_id());
		repeat (rwl_pkg::QUEUE_DEPTH) send_request(rwl_pkg::CMD_REL_RD, random_id());

		// Random: mostly writer-led sequences with random ids and queue depths,
		// the rest single requests with a random command.
		random_start = requests_sent;
		paused = 1'b0;
		while (requests_sent < random_start + RANDOM_REQUESTS) begin
			if (!paused && requests_sent >= random_start + RANDOM_REQUESTS / 2) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) < 6) begin
				n_rd = ($urandom_range(0, 7) == 0) ? rwl_pkg::QUEUE_DEPTH + 1
					: $urandom_range(0, 4);
				n_wr = ($urandom_range(0, 7) == 0) ? rwl_pkg::QUEUE_DEPTH + 1
					: $urandom_range(0, 3);
				send_request(rwl_pkg::CMD_ACQ_WR, random_id());
				repeat (n_rd) send_request(rwl_pkg::CMD_ACQ_RD, random_id());
				repeat (n_wr) send_request(rwl_pkg::CMD_ACQ_WR, random_id());
				repeat (n_wr + 1) send_request(rwl_pkg::CMD_REL_WR, random_id());
				repeat (n_rd) send_request(rwl_pkg::CMD_REL_RD, random_id());
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 3)
					send_request(rwl_pkg::CMD_ACQ_RD, random_id());
				else if (pick < 5)
					send_request(rwl_pkg::CMD_ACQ_WR, random_id());
				else if (pick < 8)
					send_request(rwl_pkg::CMD_REL_RD, random_id());
				else
					send_request(rwl_pkg::CMD_REL_WR, random_id());
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && beats_outstanding == 0)
			$display("tb_reader_writer_lock_arbiter_core OK");
		else
			$display("tb_reader_writer_lock_arbiter_core NOT OK");
		$finish;
	end

endmodule
